### hdl/target_track_state_and_vote_assert.svh
// Assertion macros shared by the track and vote checker.
`ifndef TARGET_TRACK_STATE_AND_VOTE_ASSERT_SVH
`define TARGET_TRACK_STATE_AND_VOTE_ASSERT_SVH

// Clocked on clk_i, off while rst_ni is low.
`define TTSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a result item while it is shown on the output port.
`define TTSV_ASSERT_OUT(lbl, cond, prop, msg) \
  `TTSV_ASSERT(lbl, out_valid_o && (cond) |-> (prop), msg)

`endif

### hdl/ttsv_pkg.sv
// Types and constants of the track state and digit vote block.
package ttsv_pkg;

  typedef logic [3:0]        digit_t;
  typedef logic [3:0]        count_t;
  typedef logic [1:0]        mode_t;
  typedef logic [2:0]        cfg_index_t;
  typedef logic [15:0]       coord_t;
  typedef logic signed [16:0] pred_t;

  localparam int DIFF_W = 18;
  localparam int SQ_W   = 34;
  localparam int SUM_W  = SQ_W + 1;
  localparam int R2_W   = 32;

  localparam mode_t MODE_NONE  = 2'd0;
  localparam mode_t MODE_NEW   = 2'd1;
  localparam mode_t MODE_TRACK = 2'd2;
  localparam mode_t MODE_LOST  = 2'd3;

  localparam digit_t DIGIT_NONE = 4'd0;
  localparam count_t CNT_MAX    = 4'd15;

  localparam cfg_index_t REG_CONFIRM_HITS   = 3'd0;
  localparam cfg_index_t REG_LOST_LIMIT     = 3'd1;
  localparam cfg_index_t REG_JUMP_RADIUS    = 3'd2;
  localparam cfg_index_t REG_VOTE_THRESHOLD = 3'd3;

  localparam count_t CONFIRM_HITS_RST   = 4'd3;
  localparam count_t LOST_LIMIT_RST     = 4'd8;
  localparam coord_t JUMP_RADIUS_RST    = 16'd2400;
  localparam count_t VOTE_THRESHOLD_RST = 4'd3;

endpackage

### hdl/target_track_state_and_vote.sv
// Track state machine with consecutive-hit confirmation and sliding-window digit vote.
//
//   channel | direction | handshake                 | payload
//   cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i / in_ready_o   | found, centers, predictions, raw digit
//   out     | out       | out_valid_o / out_ready_i | track_state, stable_digit, flags
//
// One item per cycle while results are taken; a result passes the input register, the
// squared-distance register and the result register before it shows on the output.
// The state update and window vote sit in the last stage, so items follow back to back.
// Reset clears control state only; no clearing pass, the window is tracked by a fill count.
// A result not taken holds the last stage; earlier stages keep filling empty slots.
module target_track_state_and_vote #(
  parameter int WINDOW_LEN    = 5,
  parameter int DIGIT_CLASSES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  ttsv_pkg::cfg_index_t cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 found_i,
  input  ttsv_pkg::coord_t     center_x_i,
  input  ttsv_pkg::coord_t     center_y_i,
  input  ttsv_pkg::pred_t      predicted_x_i,
  input  ttsv_pkg::pred_t      predicted_y_i,
  input  ttsv_pkg::digit_t     raw_digit_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ttsv_pkg::mode_t      track_state_o,
  output ttsv_pkg::digit_t     stable_digit_o,
  output logic                 filter_reinit_o,
  output logic                 motion_reset_o
);
  import ttsv_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);

  // configuration
  count_t              confirm_hits_q, lost_limit_q, vote_thr_q;
  coord_t              jump_radius_q;
  logic [R2_W-1:0]     r2_q;

  // stage 1: input register
  logic                v1_q, found1_q;
  coord_t              cx1_q, cy1_q;
  pred_t               px1_q, py1_q;
  digit_t              dig1_q;
  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [2*DIFF_W-1:0] prod_x, prod_y;

  // stage 2: squared distance
  logic                v2_q, found2_q;
  digit_t              dig2_q;
  logic [SQ_W-1:0]     sqx_q, sqy_q;
  logic [SUM_W-1:0]    d2;
  logic                far;

  // stage 3: track state and result
  logic                out_valid_q;
  mode_t               mode_q, mode_d;
  count_t              hit_q, hit_d, miss_q, miss_d, hit_base, miss_inc;
  logic [FILL_W-1:0]   fill_q, fill_d, fill_base, fill_new;
  digit_t              conf_q, conf_d, conf_base, conf_vote;
  digit_t              win_q   [WINDOW_LEN];
  digit_t              win_d   [WINDOW_LEN];
  digit_t              win_new [WINDOW_LEN];
  logic                reinit_q, reinit_d, mreset_q, mreset_d;
  logic                jump, dig_ok;

  logic                in_acc, adv2, adv3, rdy2, rdy3;

  assign rdy3       = !out_valid_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = !v1_q || rdy2;
  assign in_acc     = in_valid_i && in_ready_o;
  assign adv2       = v1_q && rdy2;
  assign adv3       = v2_q && rdy3;
  assign cfg_ready_o = 1'b1;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_hits_q <= CONFIRM_HITS_RST;
      lost_limit_q   <= LOST_LIMIT_RST;
      jump_radius_q  <= JUMP_RADIUS_RST;
      vote_thr_q     <= VOTE_THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CONFIRM_HITS:   confirm_hits_q <= cfg_data_i[3:0];
        REG_LOST_LIMIT:     lost_limit_q   <= cfg_data_i[3:0];
        REG_JUMP_RADIUS:    jump_radius_q  <= cfg_data_i;
        REG_VOTE_THRESHOLD: vote_thr_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // radius squared, refreshed every cycle
  always_ff @(posedge clk_i) begin
    r2_q <= R2_W'(jump_radius_q) * R2_W'(jump_radius_q);
  end

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_acc) begin
      v1_q <= 1'b1;
    end else if (adv2) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      found1_q <= found_i;
      cx1_q    <= center_x_i;
      cy1_q    <= center_y_i;
      px1_q    <= predicted_x_i;
      py1_q    <= predicted_y_i;
      dig1_q   <= raw_digit_i;
    end
  end

  assign dx     = $signed({2'b00, cx1_q}) - $signed({px1_q[16], px1_q});
  assign dy     = $signed({2'b00, cy1_q}) - $signed({py1_q[16], py1_q});
  assign prod_x = dx * dx;
  assign prod_y = dy * dy;

  // ---------------- stage 2 ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= 1'b1;
    end else if (adv3) begin
      v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      found2_q <= found1_q;
      dig2_q   <= dig1_q;
      sqx_q    <= prod_x[SQ_W-1:0];
      sqy_q    <= prod_y[SQ_W-1:0];
    end
  end

  assign d2  = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign far = d2 > SUM_W'(r2_q);

  // ---------------- stage 3: vote ----------------
  assign jump      = found2_q && (mode_q == MODE_TRACK) && far;
  assign fill_base = jump ? '0 : fill_q;
  assign conf_base = jump ? DIGIT_NONE : conf_q;
  assign dig_ok    = (dig2_q != DIGIT_NONE) && (dig2_q <= 4'(DIGIT_CLASSES));

  always_comb begin
    if (dig_ok) begin
      win_new[0] = dig2_q;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        win_new[i] = win_q[i-1];
      end
      fill_new = (fill_base < FILL_W'(WINDOW_LEN)) ? fill_base + 1'b1 : fill_base;
    end else begin
      win_new  = win_q;
      fill_new = fill_base;
    end
  end

  // largest class whose count reaches the threshold wins
  always_comb begin
    logic [4:0] cnt;
    conf_vote = conf_base;
    for (int v = 1; v <= DIGIT_CLASSES; v++) begin
      cnt = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        if ((FILL_W'(i) < fill_new) && (win_new[i] == 4'(v))) begin
          cnt = cnt + 5'd1;
        end
      end
      if (cnt >= {1'b0, vote_thr_q}) begin
        conf_vote = 4'(v);
      end
    end
  end

  // ---------------- stage 3: track state ----------------
  assign hit_base = jump ? '0 : hit_q;
  assign miss_inc = (miss_q < CNT_MAX) ? miss_q + 4'd1 : miss_q;

  always_comb begin
    mode_d   = mode_q;
    hit_d    = hit_q;
    miss_d   = miss_q;
    fill_d   = fill_q;
    conf_d   = conf_q;
    win_d    = win_q;
    reinit_d = 1'b0;
    mreset_d = 1'b0;
    if (found2_q) begin
      mreset_d = jump;
      reinit_d = (hit_base == '0);
      hit_d    = (hit_base < CNT_MAX) ? hit_base + 4'd1 : hit_base;
      miss_d   = '0;
      mode_d   = (hit_d >= confirm_hits_q) ? MODE_TRACK : MODE_NEW;
      fill_d   = fill_new;
      conf_d   = conf_vote;
      win_d    = win_new;
    end else begin
      miss_d = miss_inc;
      hit_d  = '0;
      if ((mode_q == MODE_NONE) || (miss_inc > lost_limit_q)) begin
        mode_d   = MODE_NONE;
        fill_d   = '0;
        conf_d   = DIGIT_NONE;
        mreset_d = 1'b1;
      end else begin
        mode_d = MODE_LOST;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= MODE_NONE;
      hit_q       <= '0;
      miss_q      <= '0;
      fill_q      <= '0;
      conf_q      <= DIGIT_NONE;
      reinit_q    <= 1'b0;
      mreset_q    <= 1'b0;
    end else begin
      if (adv3) begin
        out_valid_q <= 1'b1;
        mode_q      <= mode_d;
        hit_q       <= hit_d;
        miss_q      <= miss_d;
        fill_q      <= fill_d;
        conf_q      <= conf_d;
        reinit_q    <= reinit_d;
        mreset_q    <= mreset_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // window entries past the fill count are never read
  always_ff @(posedge clk_i) begin
    if (adv3) begin
      win_q <= win_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign track_state_o   = mode_q;
  assign stable_digit_o  = conf_q;
  assign filter_reinit_o = reinit_q;
  assign motion_reset_o  = mreset_q;

endmodule

### hdl/ttsv_chk.sv
// Port-level checker for the track and vote block, bound to its top level.
`include "target_track_state_and_vote_assert.svh"

module ttsv_chk (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input ttsv_pkg::mode_t  track_state_o,
  input ttsv_pkg::digit_t stable_digit_o,
  input logic             filter_reinit_o,
  input logic             motion_reset_o
);
  import ttsv_pkg::*;

  `TTSV_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(track_state_o) && $stable(stable_digit_o) && $stable(filter_reinit_o) && $stable(motion_reset_o), "result changed while stalled")

  // re-init only follows a hit, which leaves a new or tracked target
  `TTSV_ASSERT_OUT(a_reinit_mode, filter_reinit_o, (track_state_o == MODE_NEW) || (track_state_o == MODE_TRACK), "filter re-init without a hit")

  `TTSV_ASSERT_OUT(a_lost_quiet, track_state_o == MODE_LOST, !filter_reinit_o && !motion_reset_o, "flag raised in lost state")

  // a drop to no target clears the confirmed digit
  `TTSV_ASSERT_OUT(a_drop_clears, motion_reset_o && (track_state_o == MODE_NONE), stable_digit_o == DIGIT_NONE, "digit kept after track drop")

endmodule

bind target_track_state_and_vote ttsv_chk u_ttsv_chk (.*);

### tb/tb.sv
// Self-checking testbench for the track state machine and digit vote block.
`timescale 1ns / 100ps

module tb;
  import ttsv_pkg::*;

  localparam int WIN_DEPTH    = 5;
  localparam int NUM_CLASSES  = 8;
  localparam int PIPE_LATENCY = 3;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 75;

  typedef struct packed {
    mode_t  track_state;
    digit_t stable_digit;
    logic   filter_reinit;
    logic   motion_reset;
  } track_report_t;

  typedef struct {
    logic   found;
    coord_t cx;
    coord_t cy;
    pred_t  px;
    pred_t  py;
    digit_t digit;
  } frame_t;

  class track_vote_scoreboard;
    int confirm_hits, lost_limit, jump_radius, vote_threshold;
    int mode, hits, misses, fill, held_digit;
    int window [WIN_DEPTH];
    track_report_t reports_due [$];
    int mismatches;

    function new();
      confirm_hits   = CONFIRM_HITS_RST;
      lost_limit     = LOST_LIMIT_RST;
      jump_radius    = JUMP_RADIUS_RST;
      vote_threshold = VOTE_THRESHOLD_RST;
      mode           = MODE_NONE;
      hits           = 0;
      misses         = 0;
      fill           = 0;
      held_digit     = DIGIT_NONE;
      mismatches     = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [15:0] v);
      case (idx)
        REG_CONFIRM_HITS:   confirm_hits   = v[3:0];
        REG_LOST_LIMIT:     lost_limit     = v[3:0];
        REG_JUMP_RADIUS:    jump_radius    = v;
        REG_VOTE_THRESHOLD: vote_threshold = v[3:0];
        default: ;
      endcase
    endfunction

    // in-range digits shift into the window; largest class at threshold wins
    function void tally_digit(int d);
      int tally [NUM_CLASSES+1];
      if (d >= 1 && d <= NUM_CLASSES) begin
        for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = d;
        if (fill < WIN_DEPTH) fill++;
      end
      for (int v = 0; v <= NUM_CLASSES; v++) tally[v] = 0;
      for (int i = 0; i < fill; i++) tally[window[i]]++;
      for (int v = 1; v <= NUM_CLASSES; v++)
        if (tally[v] >= vote_threshold) held_digit = v;
    endfunction

    function void note_item(frame_t f);
      longint dx, dy, d2, r2;
      track_report_t r;
      r.filter_reinit = 1'b0;
      r.motion_reset  = 1'b0;
      if (f.found) begin
        dx = longint'(f.cx) - longint'($signed(f.px));
        dy = longint'(f.cy) - longint'($signed(f.py));
        d2 = dx * dx + dy * dy;
        r2 = longint'(jump_radius) * longint'(jump_radius);
        if (mode == MODE_TRACK && d2 > r2) begin
          hits       = 0;
          fill       = 0;
          held_digit = DIGIT_NONE;
          r.motion_reset = 1'b1;
        end
        if (hits == 0) r.filter_reinit = 1'b1;
        if (hits < CNT_MAX) hits++;
        misses = 0;
        mode = (hits >= confirm_hits) ? MODE_TRACK : MODE_NEW;
        tally_digit(f.digit);
      end else begin
        if (misses < CNT_MAX) misses++;
        hits = 0;
        if (mode == MODE_NONE || misses > lost_limit) begin
          mode       = MODE_NONE;
          fill       = 0;
          held_digit = DIGIT_NONE;
          r.motion_reset = 1'b1;
        end else begin
          mode = MODE_LOST;
        end
      end
      r.track_state  = mode_t'(mode);
      r.stable_digit = digit_t'(held_digit);
      reports_due.insert(reports_due.size(), r);
    endfunction

    function void check_result(track_report_t got);
      track_report_t want;
      if (reports_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: state %0d digit %0d reinit %0b mreset %0b",
                   got.track_state, got.stable_digit, got.filter_reinit, got.motion_reset);
        mismatches++;
        return;
      end
      want = reports_due[0];
      reports_due.delete(0);
      if (got.track_state !== want.track_state || got.stable_digit !== want.stable_digit ||
          got.filter_reinit !== want.filter_reinit || got.motion_reset !== want.motion_reset) begin
        if (mismatches < 10)
          $display("mismatch at %0t: exp %0d %0d %0b %0b, got %0d %0d %0b %0b",
                   $realtime, want.track_state, want.stable_digit, want.filter_reinit,
                   want.motion_reset, got.track_state, got.stable_digit, got.filter_reinit,
                   got.motion_reset);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  cfg_index_t cfg_index_i   = REG_CONFIRM_HITS;
  logic [15:0] cfg_data_i   = '0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic       found_i       = 1'b0;
  coord_t     center_x_i    = '0;
  coord_t     center_y_i    = '0;
  pred_t      predicted_x_i = '0;
  pred_t      predicted_y_i = '0;
  digit_t     raw_digit_i   = DIGIT_NONE;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  mode_t      track_state_o;
  digit_t     stable_digit_o;
  logic       filter_reinit_o;
  logic       motion_reset_o;

  track_vote_scoreboard score;
  logic holding   = 1'b0;
  int   in_burst  = 0;
  int   miss_left = 0;
  int   cur_digit = 1;
  int   cur_radius = JUMP_RADIUS_RST;

  target_track_state_and_vote #(
    .WINDOW_LEN    (WIN_DEPTH),
    .DIGIT_CLASSES (NUM_CLASSES)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .found_i         (found_i),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .predicted_x_i   (predicted_x_i),
    .predicted_y_i   (predicted_y_i),
    .raw_digit_i     (raw_digit_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .track_state_o   (track_state_o),
    .stable_digit_o  (stable_digit_o),
    .filter_reinit_o (filter_reinit_o),
    .motion_reset_o  (motion_reset_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly random gaps, now and then a run of back-to-back cycles
  task automatic draw_gap(inout int burst, output int gap);
    if (burst > 0) begin
      burst--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) burst = $urandom_range(10, 40);
      gap = $urandom_range(0, 17);
    end
  endtask

  function automatic pred_t offset_from(coord_t c, int m);
    int s;
    s = int'(c);
    if ($urandom_range(0, 1) == 1 && s + m <= 65535) return pred_t'(s + m);
    return pred_t'(s - m);
  endfunction

  // hits near the prediction with a sticky digit, miss runs, edge and far jumps
  function automatic frame_t make_frame();
    frame_t f;
    int kind, mx, my;
    f.found = 1'b0;
    f.cx    = 16'($urandom);
    f.cy    = 16'($urandom);
    f.px    = 17'($urandom);
    f.py    = 17'($urandom);
    f.digit = 4'($urandom_range(0, 15));
    if (miss_left > 0) begin
      miss_left--;
      return f;
    end
    if ($urandom_range(0, 9) == 0) begin
      miss_left = $urandom_range(0, 15);
      return f;
    end
    f.found = 1'b1;
    if ($urandom_range(0, 19) == 0) cur_digit = $urandom_range(1, NUM_CLASSES);
    if ($urandom_range(0, 3) != 0) f.digit = digit_t'(cur_digit);
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      mx = $urandom_range(0, cur_radius / 2);
      my = $urandom_range(0, cur_radius / 2);
    end else if (kind < 84) begin
      // on the circle or one step past it
      mx = (cur_radius < 65535) ? cur_radius + $urandom_range(0, 1) : cur_radius;
      my = 0;
    end else if (kind < 90) begin
      mx = 65535;
      my = $urandom_range(0, 65535);
    end else begin
      return f;
    end
    f.px = offset_from(f.cx, mx);
    f.py = offset_from(f.cy, my);
    return f;
  endfunction

  task automatic send_frame(input frame_t f, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    found_i       <= f.found;
    center_x_i    <= f.cx;
    center_y_i    <= f.cy;
    predicted_x_i <= f.px;
    predicted_y_i <= f.py;
    raw_digit_i   <= f.digit;
    do @(posedge clk_i); while (!in_ready_o);
    score.note_item(f);
  endtask

  task automatic send_directed(input logic found, input int cx, cy, px, py, dg);
    frame_t f;
    int gap;
    f.found = found;
    f.cx    = coord_t'(cx);
    f.cy    = coord_t'(cy);
    f.px    = pred_t'(px);
    f.py    = pred_t'(py);
    f.digit = digit_t'(dg);
    draw_gap(in_burst, gap);
    send_frame(f, gap);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (score.reports_due.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // all four registers plus one unused index; spare high bits on the 4-bit ones
  task automatic write_regs(input int ch, ll, jr, vt);
    cfg_index_t  idx [5];
    logic [15:0] dat [5];
    idx[0] = REG_CONFIRM_HITS;   dat[0] = (16'($urandom) & 16'hFFF0) | 16'(ch);
    idx[1] = REG_LOST_LIMIT;     dat[1] = (16'($urandom) & 16'hFFF0) | 16'(ll);
    idx[2] = REG_JUMP_RADIUS;    dat[2] = 16'(jr);
    idx[3] = REG_VOTE_THRESHOLD; dat[3] = (16'($urandom) & 16'hFFF0) | 16'(vt);
    idx[4] = cfg_index_t'($urandom_range(4, 7));
    dat[4] = 16'($urandom);
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= dat[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      score.set_reg(idx[i], dat[i]);
    end
    cfg_valid_i <= 1'b0;
    cur_radius = jr;
  endtask

  // result side
  initial begin
    int gap, burst, taken;
    track_report_t got;
    burst = 0;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken == HOLD_AT) begin
        gap = HOLD_CYCLES;
        holding <= 1'b1;
      end else begin
        draw_gap(burst, gap);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      holding     <= 1'b0;
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.track_state   = track_state_o;
      got.stable_digit  = stable_digit_o;
      got.filter_reinit = filter_reinit_o;
      got.motion_reset  = motion_reset_o;
      score.check_result(got);
      taken++;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int ch, ll, jr, vt, gap, sel;
    frame_t f;
    score = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_regs(CONFIRM_HITS_RST, LOST_LIMIT_RST, JUMP_RADIUS_RST, VOTE_THRESHOLD_RST);
    send_directed(1'b0, 0, 0, 0, 0, 4);                 // miss with no target
    repeat (3) send_directed(1'b1, 1000, 1000, 1000, 1000, 5);
    send_directed(1'b1, 5000, 300, 2600, 300, 7);       // exactly on the radius
    send_directed(1'b1, 5001, 300, 2600, 300, 15);      // one past: jump, digit out of range
    send_directed(1'b1, 5000, 300, 5000, 300, 0);
    send_directed(1'b1, 65535, 65535, 65535, 65535, 8);
    send_directed(1'b1, 0, 0, -65536, 65535, 3);        // extreme jump
    repeat (3) send_directed(1'b1, 40000, 20, 40010, -20, 2);
    repeat (2) send_directed(1'b1, 40000, 20, 40000, 20, 6);
    repeat (9) send_directed(1'b0, 65535, 0, 65535, -65536, 1);
    send_directed(1'b1, 123, 456, 120, 450, 1);

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin ch = 0;  ll = 0;  jr = 0;     vt = 0;  end
        1: begin ch = 15; ll = 15; jr = 65535; vt = 15; end
        2: begin ch = 1;  ll = 14; jr = $urandom_range(200, 3000); vt = 8; end
        default: begin
          ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 5);
          ll = $urandom_range(0, 15);
          vt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 5);
          sel = $urandom_range(0, 3);
          if (sel == 0)      jr = $urandom_range(0, 65535);
          else if (sel == 3) jr = ($urandom_range(0, 1) == 1) ? 65535 : 0;
          else               jr = $urandom_range(50, 4000);
        end
      endcase
      write_regs(ch, ll, jr, vt);
      repeat (PHASE_ITEMS) begin
        f = make_frame();
        draw_gap(in_burst, gap);
        if (holding) gap = 0;
        send_frame(f, gap);
      end
    end

    settle();
    repeat (PIPE_LATENCY * 4) @(posedge clk_i);
    if (score.mismatches == 0 && score.reports_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/ttsv_pkg.sv
hdl/target_track_state_and_vote.sv
hdl/ttsv_chk.sv
tb/tb.sv
